// File: sv/lz4bd_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder package
// Shared constants and types for the LZ4 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package lz4bd_pkg;
  localparam int WindowBytes = 65536;
  localparam int AddrW = $clog2(WindowBytes);
  localparam int DrainBytes = 16;
  localparam int DrainW = $clog2(DrainBytes + 1);
  localparam int LenW = 33;
  localparam logic [LenW-1:0] LenSat = {LenW{1'b1}};
  localparam logic [31:0] CapReset = 32'd65536;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
endpackage
`default_nettype wire

// File: sv/lz4_block_decoder.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder
// Parses LZ4 sequences from a byte stream and copies matches from history.
// ----------------------------------------------------------------------------
// A feed transfer is accepted only while the output register is empty; a result waits in
// that register, which holds off input until it is taken. A literal that carries the last
// byte gives two results (the byte, then the end result); some feeds give no result.
// A drain copies up to 16 pending match bytes: a start state, then per byte a registered
// history read, then emit and write back; input is held off while the copy runs.
// Reset is synchronous; it clears the parser state and sets the capacity to 65536.
`default_nettype none
module lz4_block_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] compressed_byte
  input  wire logic        s_tuser,   // [0] operation
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] out_byte, [39:8] total_length
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic             m_tlast,   // last_of_run
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);
  import lz4bd_pkg::*;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT, PH_MATCH, PH_SKIP
  } phase_t;
  typedef enum logic [1:0] {C_IDLE, C_READ, C_WAIT} copy_t;

  logic [31:0] capacity;
  phase_t phase;
  copy_t copy;
  logic [3:0] match_nibble;
  logic [LenW-1:0] literals_left, match_left, produced;
  logic [15:0] match_distance;
  logic [DrainW-1:0] drain_cnt;
  logic pend_end, pend_ok;

  logic [7:0] history [WindowBytes];
  logic [7:0] rd_data;
  logic [AddrW-1:0] rd_addr;

  logic [7:0] byte_in;
  logic [LenW:0] room;
  assign byte_in = s_tdata;
  // Room left in the block; negative once the output has passed a lowered capacity.
  assign room = {2'b00, capacity} - {1'b0, produced};
  assign rd_addr = produced[AddrW-1:0] - match_distance;

  // Output register: accept a new item only when the output stage is free and no copy runs.
  logic accept;
  assign s_tready = (copy == C_IDLE) && !m_tvalid;
  assign accept = s_tvalid && s_tready;

  function automatic logic [LenW-1:0] sat_add(input logic [LenW-1:0] a,
                                              input logic [7:0] b);
    logic [LenW:0] v;
    v = {1'b0, a} + {{LenW-7{1'b0}}, b};
    return v[LenW] ? LenSat : v[LenW-1:0];
  endfunction

  // A length is too long when it exceeds a non-negative room.
  function automatic logic over_cap(input logic [LenW-1:0] want_len);
    return !room[LenW] && ({1'b0, want_len} > room);
  endfunction

  // History memory: read for match copies, written for every decoded byte.
  logic       wr_en;
  logic [7:0] wr_byte;
  always_ff @(posedge clk) begin
    if (wr_en) history[produced[AddrW-1:0]] <= wr_byte;
    rd_data <= history[rd_addr];
  end

  // Combinational write request.
  always_comb begin
    wr_en = 1'b0;
    wr_byte = byte_in;
    if (accept && s_tuser == OP_FEED && phase == PH_LITERALS) wr_en = 1'b1;
    if (copy == C_WAIT && (!m_tvalid || m_tready)) begin
      wr_en = 1'b1;
      wr_byte = rd_data;
    end
  end

  // Parser, copy sequencer and output register.
  always_ff @(posedge clk) begin
    logic [LenW-1:0] len;
    logic [15:0] offset_val;
    logic m_tvalid_next;
    logic [39:0] m_tdata_next;
    logic [1:0] m_tuser_next;
    logic m_tlast_next;
    if (rst) begin
      capacity <= CapReset;
      phase <= PH_TOKEN;
      copy <= C_IDLE;
      match_nibble <= '0;
      literals_left <= '0;
      match_left <= '0;
      match_distance <= '0;
      produced <= '0;
      drain_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid_next = m_tvalid && !m_tready;
      m_tdata_next = m_tdata;
      m_tuser_next = m_tuser;
      m_tlast_next = m_tlast;
      if (cfg_we) capacity <= cfg_data;
      if (accept && s_tuser == OP_DRAIN) begin
        if (phase == PH_MATCH && match_left != '0) begin
          copy <= C_READ;
          drain_cnt <= '0;
        end
      end else if (accept) begin
        m_tdata_next = '0;
        m_tuser_next = ST_BYTE;
        m_tlast_next = 1'b1;
        unique case (phase)
          PH_TOKEN, PH_LIT_EXT: begin
            if (phase == PH_TOKEN) begin
              match_nibble <= byte_in[3:0];
              len = {{LenW-4{1'b0}}, byte_in[7:4]};
            end else begin
              len = sat_add(literals_left, byte_in);
            end
            literals_left <= len;
            if (phase == PH_TOKEN && byte_in[7:4] == 4'hF) begin
              if (s_tlast) begin
                m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
              end else phase <= PH_LIT_EXT;
            end else if (phase == PH_LIT_EXT && byte_in == 8'hFF && !s_tlast) begin
              phase <= PH_LIT_EXT;
            end else if (s_tlast) begin
              m_tvalid_next = 1'b1;
              phase <= PH_TOKEN;
              m_tuser_next = (len == '0) ? ST_DONE : ST_ERROR;
              if (len == '0) m_tdata_next[39:8] = produced[31:0];
              produced <= '0;
            end else if (over_cap(len)) begin
              m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
              phase <= PH_SKIP;
            end else phase <= (len == '0) ? PH_OFF_LO : PH_LITERALS;
          end
          PH_LITERALS: begin
            // The byte result and the end result are two items of one transfer.
            m_tvalid_next = 1'b1;
            m_tdata_next[7:0] = byte_in;
            m_tlast_next = !s_tlast;
            literals_left <= literals_left - LenW'(1);
            produced <= sat_add(produced, 8'd1);
            if (s_tlast) phase <= PH_TOKEN;
            else if (literals_left == LenW'(1)) phase <= PH_OFF_LO;
          end
          PH_OFF_LO: begin
            if (s_tlast) begin
              m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
              phase <= PH_TOKEN;
            end else begin
              match_distance <= {8'd0, byte_in};
              phase <= PH_OFF_HI;
            end
          end
          PH_OFF_HI: begin
            offset_val = {byte_in, match_distance[7:0]};
            match_distance <= offset_val;
            len = {{LenW-5{1'b0}}, 1'b0, match_nibble} + LenW'(4);
            match_left <= len;
            if (s_tlast || offset_val == '0 ||
                {{LenW-16{1'b0}}, offset_val} > produced) begin
              m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
              phase <= s_tlast ? PH_TOKEN : PH_SKIP;
            end else if (match_nibble == 4'hF) phase <= PH_MATCH_EXT;
            else if (over_cap(len)) begin
              m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
              phase <= PH_SKIP;
            end else phase <= PH_MATCH;
          end
          PH_MATCH_EXT: begin
            len = sat_add(match_left, byte_in);
            match_left <= len;
            if (s_tlast) begin
              m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
              phase <= PH_TOKEN;
            end else if (byte_in != 8'hFF) begin
              if (over_cap(len)) begin
                m_tvalid_next = 1'b1; m_tuser_next = ST_ERROR; produced <= '0;
                phase <= PH_SKIP;
              end else phase <= PH_MATCH;
            end
          end
          PH_SKIP: if (s_tlast) phase <= PH_TOKEN;
          PH_MATCH: ;
          default: ;
        endcase
      end
      // Literal carrying the last byte: emit the end result after the byte.
      if (pend_end && m_tvalid && m_tready) begin
        m_tvalid_next = 1'b1;
        m_tdata_next = '0;
        m_tlast_next = 1'b1;
        m_tuser_next = pend_ok ? ST_DONE : ST_ERROR;
        if (pend_ok) m_tdata_next[39:8] = produced[31:0];
        produced <= '0;
      end
      // Match copy: read a history byte, then emit and record it.
      unique case (copy)
        C_IDLE: ;
        C_READ: copy <= C_WAIT;
        C_WAIT: if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next = {32'd0, rd_data};
          m_tuser_next = ST_BYTE;
          produced <= sat_add(produced, 8'd1);
          match_left <= match_left - LenW'(1);
          drain_cnt <= drain_cnt + DrainW'(1);
          m_tlast_next = (match_left == LenW'(1)) ||
                         (drain_cnt == DrainW'(DrainBytes - 1));
          if (match_left == LenW'(1)) phase <= PH_TOKEN;
          copy <= ((match_left == LenW'(1)) || (drain_cnt == DrainW'(DrainBytes - 1)))
                  ? C_IDLE : C_READ;
        end
        default: copy <= C_IDLE;
      endcase
      m_tvalid <= m_tvalid_next;
      m_tdata <= m_tdata_next;
      m_tuser <= m_tuser_next;
      m_tlast <= m_tlast_next;
    end
  end

  // Pending end-of-block result after a literal that carried the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_end <= 1'b0;
      pend_ok <= 1'b0;
    end else if (accept && s_tuser == OP_FEED && phase == PH_LITERALS && s_tlast) begin
      pend_end <= 1'b1;
      pend_ok <= (literals_left == LenW'(1));
    end else if (pend_end && m_tvalid && m_tready) begin
      pend_end <= 1'b0;
    end
  end

  // Checks.
  a_no_accept_copy: assert property (@(posedge clk) disable iff (rst)
    copy != C_IDLE |-> !s_tready) else $error("accept during copy");
  a_copy_in_match: assert property (@(posedge clk) disable iff (rst)
    copy == C_WAIT |-> phase == PH_MATCH) else $error("copy outside match");
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    copy == C_READ |=> copy == C_WAIT) else $error("read not followed by wait");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder testbench
// Streams compressed blocks and drain requests into the decoder. A built-in
// decoder model predicts every result, and each output transfer is checked
// against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import lz4bd_pkg::*;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 80;

  typedef enum logic [2:0] {
    P_TOKEN, P_LIT_EXT, P_LITERALS, P_OFF_LO, P_OFF_HI, P_MATCH_EXT, P_MATCH, P_SKIP
  } parse_t;

  typedef struct {
    logic [7:0]  out_byte;
    status_t     status;
    logic [31:0] total_length;
    logic        last_of_run;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  lz4_block_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Decoder model state.
  localparam longint unsigned LenMax = 64'h1_FFFF_FFFF;
  logic [31:0]     capacity = CapReset;
  parse_t          parse = P_TOKEN;
  logic [3:0]      nibble = '0;
  longint unsigned lits_left = 0;
  longint unsigned copy_left = 0;
  logic [15:0]     distance = '0;
  longint unsigned produced = 0;
  logic [7:0]      history [WindowBytes];

  decoded_t  decoded_q[$];
  bit        failed = 1'b0;
  bit        steady = 1'b0;
  int        items_sent = 0;
  logic [7:0] block_q[$];

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    longint unsigned v;
    v = a + b;
    return (v > LenMax) ? LenMax : v;
  endfunction

  function automatic bit too_long(longint unsigned len);
    longint unsigned room;
    room = longint'(capacity) - produced;
    return len > room;
  endfunction

  function automatic void emit(logic [7:0] b, status_t st, longint unsigned total);
    decoded_t d;
    d.out_byte = b;
    d.status = st;
    d.total_length = total[31:0];
    d.last_of_run = 1'b0;
    decoded_q.push_back(d);
  endfunction

  function automatic void store(logic [7:0] b);
    history[produced[15:0]] = b;
    produced = sat_add(produced, 1);
  endfunction

  function automatic void block_error(bit last);
    emit(8'd0, ST_ERROR, 0);
    produced = 0;
    parse = last ? P_TOKEN : P_SKIP;
  endfunction

  function automatic void block_done();
    emit(8'd0, ST_DONE, produced);
    produced = 0;
    parse = P_TOKEN;
  endfunction

  function automatic void literal_length_known(bit last);
    if (last) begin
      if (lits_left == 0) block_done();
      else block_error(1'b1);
    end else if (too_long(lits_left)) begin
      block_error(1'b0);
    end else begin
      parse = (lits_left == 0) ? P_OFF_LO : P_LITERALS;
    end
  endfunction

  function automatic void match_length_known(bit last);
    if (last || too_long(copy_left)) block_error(last);
    else parse = P_MATCH;
  endfunction

  // Predict the results of one accepted input transfer.
  function automatic void decode_step(logic op, logic [7:0] b, logic last);
    int q_base;
    int n;
    logic [15:0] src;
    logic [15:0] offset_val;
    q_base = decoded_q.size();
    n = 0;
    if (op == OP_DRAIN) begin
      if (parse == P_MATCH) begin
        while (copy_left > 0 && n < DrainBytes) begin
          src = produced[15:0] - distance;
          emit(history[src], ST_BYTE, 0);
          store(history[src]);
          copy_left--;
          n++;
        end
        if (copy_left == 0) parse = P_TOKEN;
      end
    end else begin
      case (parse)
        P_TOKEN: begin
          nibble = b[3:0];
          lits_left = b[7:4];
          if (lits_left == 15) begin
            if (last) block_error(1'b1);
            else parse = P_LIT_EXT;
          end else begin
            literal_length_known(last);
          end
        end
        P_LIT_EXT: begin
          lits_left = sat_add(lits_left, b);
          if (!(b == 8'hFF && !last)) literal_length_known(last);
        end
        P_LITERALS: begin
          emit(b, ST_BYTE, 0);
          store(b);
          lits_left--;
          if (last) begin
            if (lits_left == 0) block_done();
            else block_error(1'b1);
          end else if (lits_left == 0) begin
            parse = P_OFF_LO;
          end
        end
        P_OFF_LO: begin
          if (last) block_error(1'b1);
          else begin
            distance = {8'd0, b};
            parse = P_OFF_HI;
          end
        end
        P_OFF_HI: begin
          offset_val = {b, distance[7:0]};
          distance = offset_val;
          if (last || offset_val == 0 || longint'(offset_val) > produced) begin
            block_error(last);
          end else begin
            copy_left = nibble + 4;
            if (nibble == 4'hF) parse = P_MATCH_EXT;
            else match_length_known(1'b0);
          end
        end
        P_MATCH_EXT: begin
          copy_left = sat_add(copy_left, b);
          if (last) block_error(1'b1);
          else if (b != 8'hFF) match_length_known(1'b0);
        end
        P_SKIP: if (last) parse = P_TOKEN;
        default: ;
      endcase
    end
    if (decoded_q.size() > q_base) decoded_q[decoded_q.size()-1].last_of_run = 1'b1;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // Send one input transfer; returns at the edge where it is accepted.
  task automatic send_item(logic op, logic [7:0] b, logic last);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= op;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    decode_step(op, b, last);
    items_sent++;
  endtask

  // Drop valid and wait for all predicted results plus settling time.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    capacity = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Append a length extension (the part beyond 15) to the block.
  task automatic add_extension(int rest);
    while (rest >= 255) begin
      block_q.push_back(8'hFF);
      rest -= 255;
    end
    block_q.push_back(rest[7:0]);
  endtask

  // Append one sequence; a match length of zero makes it the closing one.
  task automatic add_sequence(int lits, int mlen, int offset);
    int mcode;
    mcode = (mlen == 0) ? 0 : mlen - 4;
    block_q.push_back({(lits >= 15) ? 4'hF : lits[3:0], (mcode >= 15) ? 4'hF : mcode[3:0]});
    if (lits >= 15) add_extension(lits - 15);
    repeat (lits) block_q.push_back(8'($urandom));
    if (mlen != 0) begin
      block_q.push_back(offset[7:0]);
      block_q.push_back(offset[15:8]);
      if (mcode >= 15) add_extension(mcode - 15);
    end
  endtask

  // Feed the queued block, draining each match as it becomes pending.
  // A cut position ends the block early with the last flag.
  task automatic run_block(int cut, int noise);
    int i;
    bit last;
    i = 0;
    last = 1'b0;
    while (i < block_q.size() && !last) begin
      last = (i == block_q.size() - 1) || (i == cut);
      send_item(OP_FEED, block_q[i], last);
      i++;
      if (noise > 0 && $urandom_range(0, noise) == 0)
        send_item(OP_DRAIN, 8'($urandom), 1'($urandom));
      while (parse == P_MATCH) begin
        if (noise > 0 && $urandom_range(0, noise) == 0)
          send_item(OP_FEED, 8'($urandom), 1'b0);
        send_item(OP_DRAIN, 8'($urandom), 1'($urandom));
      end
    end
    block_q.delete();
  endtask

  task automatic test_directed();
    // An empty block reports done with zero length.
    add_sequence(0, 0, 0);
    run_block(-1, 0);
    // Extreme literal values, then a one-byte offset that replicates.
    block_q.push_back(8'h21);
    block_q.push_back(8'h00);
    block_q.push_back(8'hFF);
    block_q.push_back(8'h01);
    block_q.push_back(8'h00);
    block_q.push_back(8'h10);
    block_q.push_back(8'hA5);
    run_block(-1, 0);
    // An offset of zero is malformed; the rest is skipped up to the last byte.
    add_sequence(1, 4, 0);
    block_q.push_back(8'h77);
    run_block(-1, 0);
    // Truncation inside the literals.
    add_sequence(3, 0, 0);
    run_block(2, 0);
    // Drain with nothing pending, and a feed while a match is pending.
    send_item(OP_DRAIN, 8'h00, 1'b0);
    add_sequence(2, 20, 2);
    add_sequence(0, 0, 0);
    run_block(-1, 1);
  endtask

  // Random well-formed blocks with occasional corruption and noise.
  task automatic test_random(int quota);
    int goal;
    int gp;
    int nseq;
    int lits;
    int mlen;
    int off;
    int pick;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      steady = ($urandom_range(0, 3) == 0);
      gp = 0;
      nseq = $urandom_range(1, 3);
      repeat (nseq - 1) begin
        pick = $urandom_range(0, 19);
        lits = (pick < 14) ? $urandom_range(0, 14) :
               (pick < 19) ? $urandom_range(15, 40) : $urandom_range(255, 290);
        if (gp + lits == 0) lits = 1;
        gp += lits;
        pick = $urandom_range(0, 19);
        mlen = (pick < 15) ? $urandom_range(4, 18) :
               (pick < 19) ? $urandom_range(19, 60) : $urandom_range(270, 300);
        off = $urandom_range(1, (gp > 65535) ? 65535 : gp);
        pick = $urandom_range(0, 14);
        if (pick == 0) off = 0;
        else if (pick == 1) off = $urandom_range(gp + 1, 65535);
        add_sequence(lits, mlen, off);
        gp += mlen;
      end
      add_sequence($urandom_range(0, 20), 0, 0);
      pick = $urandom_range(0, 9);
      run_block((pick == 0) ? $urandom_range(0, block_q.size() - 1) : -1,
                (pick == 1) ? 3 : 0);
      // Stray bytes between blocks, ending with a last flag.
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) send_item(OP_FEED, 8'($urandom), 1'b0);
        send_item(OP_FEED, 8'($urandom), 1'b1);
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random stall before each output transfer.
  initial begin
    int n;
    forever begin
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
      n = draw_wait();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest prediction.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: data %h status %0d last %b", m_tdata, m_tuser, m_tlast);
        failed = 1'b1;
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata[7:0] !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, m_tdata[7:0]);
          failed = 1'b1;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser);
          failed = 1'b1;
        end
        if (m_tdata[39:8] !== want.total_length) begin
          $error("total_length: expected %0d, actual %0d", want.total_length,
                 m_tdata[39:8]);
          failed = 1'b1;
        end
        if (m_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %b, actual %b", want.last_of_run, m_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("lz4_block_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(30);
    write_capacity(32'hFFFF_FFFF);
    test_random(30);
    write_capacity(32'd0);
    test_random(10);
    write_capacity(32'd50);
    test_random(30);
    write_capacity($urandom_range(20, 400));
    test_random(30);
    write_capacity(CapReset);
    test_random(20);
    wait_idle();
    if (!failed && decoded_q.size() == 0) begin
      $display("lz4_block_decoder: match");
    end else begin
      $display("lz4_block_decoder: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
sv/lz4bd_pkg.sv
sv/lz4_block_decoder.sv
verif/tb_top.sv
